### design/tve_pkg.sv
// Shared types, constants and the round mixing function for the modified TEA encryptor.
// No dependencies; imported by every module of the block.
`default_nettype none

package tve_pkg;

   typedef logic [31:0] word_type;

   // Per-round increment of the running sum, and the extra XOR constants of each half-round
   localparam word_type ROUND_STEP  = 32'h9e37_79b9;
   localparam word_type LEFT_TWEAK  = 32'h0011_4514;
   localparam word_type RIGHT_TWEAK = 32'h0191_9810;

   // Register indexes of the key port
   typedef enum logic [1:0] {
      CSR_KEY_0 = 2'd0,
      CSR_KEY_1 = 2'd1,
      CSR_KEY_2 = 2'd2,
      CSR_KEY_3 = 2'd3
   } csr_index_type;

   typedef struct packed {
      word_type k0;
      word_type k1;
      word_type k2;
      word_type k3;
   } key_set_type;

   // One block as it moves down the pipeline, with its valid bit
   typedef struct packed {
      logic     valid;
      word_type left;
      word_type right;
   } block_type;

   // Running sum after round idx (counted from zero); wraps modulo 2^32
   function automatic word_type round_sum_of(input int idx);
      return word_type'(ROUND_STEP * word_type'(idx + 1));
   endfunction

   // ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb) ^ tweak
   function automatic word_type mix_term(input word_type x, input word_type sum,
                                         input word_type ka, input word_type kb,
                                         input word_type tweak);
      word_type t1;
      word_type t2;
      word_type t3;
      t1 = (x << 4) + ka;
      t2 = x + sum;
      t3 = (x >> 5) + kb;
      return t1 ^ t2 ^ t3 ^ tweak;
   endfunction

endpackage

`default_nettype wire

### design/tea_variant_encrypt.sv
// Modified TEA encryptor, fully unrolled: one register stage per half-round.
// rsp_valid and the result words come straight from the last half-round register.
// Throughput: one item per cycle while busy is low; each half-round adder/XOR chain sits between two registers.
// Reset clears keys and all pipeline valid bits; busy is high during reset and in the first cycle
// after reset, and low from then on. The receiver cannot stall: rsp_valid lasts one cycle.
`default_nettype none

module tea_variant_encrypt
   import tve_pkg::*;
#(
   parameter int ROUNDS = 32
)
(
   input  wire logic       clock,
   input  wire logic       reset,
   // item input
   input  wire logic       start,
   output logic            busy,
   input  wire word_type   req_left_in,
   input  wire word_type   req_right_in,
   // result output
   output logic            rsp_valid,
   output word_type        rsp_left_out,
   output word_type        rsp_right_out,
   // key write port
   input  wire logic       csr_write_enable,
   input  wire logic [1:0] csr_index,
   input  wire word_type   csr_write_data
);

   localparam int LATENCY = 2 * ROUNDS;

   key_set_type keys;
   block_type   stage [0:ROUNDS];
   logic        busy_ff;
   logic        busy_in;
   logic        accept;

   // Key registers
   tve_key_regs u_keys (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .keys             (keys)
   );

   // Hold busy for the cycle that follows reset
   assign busy_in = 1'b0;
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= busy_in;
      end
   end
   assign busy   = busy_ff;
   assign accept = start && !busy_ff;

   // Feed the pipeline head
   assign stage[0].valid = accept;
   assign stage[0].left  = req_left_in;
   assign stage[0].right = req_right_in;

   // Chain the rounds, each with its fixed running sum
   for (genvar r = 0; r < ROUNDS; r++) begin : g_round
      localparam word_type RoundSum = round_sum_of(r);
      tve_round u_round (
         .clock     (clock),
         .reset     (reset),
         .round_sum (RoundSum),
         .keys      (keys),
         .blk_in    (stage[r]),
         .blk_out   (stage[r+1])
      );
   end

   assign rsp_valid     = stage[ROUNDS].valid;
   assign rsp_left_out  = stage[ROUNDS].left;
   assign rsp_right_out = stage[ROUNDS].right;

   // A result only ever comes from an item that the pipeline head accepted earlier
   a_result_has_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LATENCY))
      else $error("result strobe without a matching accepted item");

   // Out of reset the pipeline never refuses an item
   a_never_busy: assert property (@(posedge clock) disable iff (reset)
      !reset |=> !busy)
      else $error("busy raised outside the post-reset cycle");

   // A key write to word 2 lands in that word
   a_key_write: assert property (@(posedge clock) disable iff (reset)
      (csr_write_enable && csr_index == CSR_KEY_2) |=> keys.k2 == $past(csr_write_data))
      else $error("key word 2 write lost");

endmodule

`default_nettype wire

### design/tve_key_regs.sv
// Key register file: four 32-bit key words written through the CSR write port.
// Depends on tve_pkg for the key set struct and register indexes.
`default_nettype none

module tve_key_regs
   import tve_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_index,
   input  wire word_type    csr_write_data,
   output key_set_type      keys
);

   key_set_type keys_ff;
   key_set_type keys_in;

   // Decode the index and replace the addressed word
   always_comb begin
      keys_in = keys_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_KEY_0: keys_in.k0 = csr_write_data;
            CSR_KEY_1: keys_in.k1 = csr_write_data;
            CSR_KEY_2: keys_in.k2 = csr_write_data;
            CSR_KEY_3: keys_in.k3 = csr_write_data;
            default:   keys_in = keys_ff;
         endcase
      end
   end

   // Hold keys; clear on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         keys_ff <= '0;
      end else begin
         keys_ff <= keys_in;
      end
   end

   assign keys = keys_ff;

endmodule

`default_nettype wire

### design/tve_round.sv
// One cipher round as two register stages: left half-round, then right half-round.
// Depends on tve_pkg for block/key types and the mixing function.
`default_nettype none

module tve_round
   import tve_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire word_type    round_sum,
   input  wire key_set_type keys,
   input  wire block_type   blk_in,
   output block_type        blk_out
);

   block_type mid_ff;
   block_type mid_in;
   block_type out_ff;
   block_type out_in;

   // Update the left word from the right word
   always_comb begin
      mid_in.valid = blk_in.valid;
      mid_in.left  = blk_in.left
                     + mix_term(blk_in.right, round_sum, keys.k0, keys.k1, LEFT_TWEAK);
      mid_in.right = blk_in.right;
   end

   // Update the right word from the new left word
   always_comb begin
      out_in.valid = mid_ff.valid;
      out_in.left  = mid_ff.left;
      out_in.right = mid_ff.right
                     + mix_term(mid_ff.left, round_sum, keys.k2, keys.k3, RIGHT_TWEAK);
   end

   // Advance both stages; only the valid bits see reset
   always_ff @(posedge clock) begin
      if (reset) begin
         mid_ff.valid <= 1'b0;
         out_ff.valid <= 1'b0;
      end else begin
         mid_ff.valid <= mid_in.valid;
         out_ff.valid <= out_in.valid;
      end
      mid_ff.left  <= mid_in.left;
      mid_ff.right <= mid_in.right;
      out_ff.left  <= out_in.left;
      out_ff.right <= out_in.right;
   end

   assign blk_out = out_ff;

endmodule

`default_nettype wire

### verif/tb_top.sv
// Self-checking testbench for tea_variant_encrypt: drives blocks and key writes, predicts
// each ciphertext with its own cipher model and compares every result. Depends on tve_pkg.
`timescale 1ns / 100ps

module tb_top;
   import tve_pkg::*;

   localparam int       ROUNDS       = 32;
   localparam int       PIPE_LATENCY = 2 * ROUNDS;
   localparam word_type SUM_STEP     = 32'h9e37_79b9;
   localparam word_type LEFT_XOR     = 32'h0011_4514;
   localparam word_type RIGHT_XOR    = 32'h0191_9810;
   localparam int       MAX_REPORTS  = 10;

   typedef struct {
      word_type left;
      word_type right;
   } cipher_words_type;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   word_type   req_left_in;
   word_type   req_right_in;
   logic       rsp_valid;
   word_type   rsp_left_out;
   word_type   rsp_right_out;
   logic       csr_write_enable;
   logic [1:0] csr_index;
   word_type   csr_write_data;

   // key registers as the block should hold them
   word_type         key_shadow [4];
   // ciphertexts still owed by the block, oldest first
   cipher_words_type pending_ciphertexts [$];
   int               failure_count;
   bit               sender_idles;

   tea_variant_encrypt #(.ROUNDS(ROUNDS)) u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_left_in      (req_left_in),
      .req_right_in     (req_right_in),
      .rsp_valid        (rsp_valid),
      .rsp_left_out     (rsp_left_out),
      .rsp_right_out    (rsp_right_out),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // generous bound on the whole run
   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // one half-round term: shifted copies plus keys, running sum and tweak, all XORed
   function automatic word_type half_round(input word_type x, input word_type acc,
                                           input word_type ka, input word_type kb,
                                           input word_type tweak);
      return ((x << 4) + ka) ^ (x + acc) ^ ((x >> 5) + kb) ^ tweak;
   endfunction

   function automatic cipher_words_type encrypt_block(input word_type left,
                                                      input word_type right);
      cipher_words_type result;
      word_type         acc;
      acc = '0;
      for (int r = 0; r < ROUNDS; r++) begin
         acc   = acc + SUM_STEP;
         left  = left + half_round(right, acc, key_shadow[0], key_shadow[1], LEFT_XOR);
         right = right + half_round(left, acc, key_shadow[2], key_shadow[3], RIGHT_XOR);
      end
      result.left  = left;
      result.right = right;
      return result;
   endfunction

   // pick a data word, weighted toward edges and single-bit patterns
   function automatic word_type pick_word();
      int sel;
      sel = $urandom_range(9);
      case (sel)
         0: begin
            return '0;
         end
         1: begin
            return '1;
         end
         2: begin
            return word_type'(1) << $urandom_range(31);
         end
         3: begin
            return ~(word_type'(1) << $urandom_range(31));
         end
         default: begin
            return $urandom;
         end
      endcase
   endfunction

   task automatic note_failure(input string msg);
      failure_count++;
      if (failure_count <= MAX_REPORTS) begin
         $display("[%0t] mismatch: %s", $realtime, msg);
      end
   endtask

   // send one item; start stays high so back-to-back items need no extra edge
   task automatic send_block(input word_type left, input word_type right);
      // when sender_idles is set, about 8 items in 100 follow an idle gap with start low
      if (sender_idles && $urandom_range(99) < 8) begin
         start        <= 1'b0;
         req_left_in  <= $urandom;
         req_right_in <= $urandom;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start        <= 1'b1;
      req_left_in  <= left;
      req_right_in <= right;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_ciphertexts.push_back(encrypt_block(left, right));
   endtask

   // drop start and hold until every owed ciphertext has come out
   task automatic wait_for_drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending_ciphertexts.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // write all four key words on consecutive edges; only called while idle
   task automatic load_keys(input word_type k0, input word_type k1,
                            input word_type k2, input word_type k3);
      word_type values [4];
      values = '{k0, k1, k2, k3};
      for (int i = 0; i < 4; i++) begin
         csr_write_enable <= 1'b1;
         csr_index        <= csr_index_type'(i);
         csr_write_data   <= values[i];
         @(posedge clock);
         key_shadow[i] = values[i];
      end
      csr_write_enable <= 1'b0;
      csr_write_data   <= $urandom;
      @(posedge clock);
   endtask

   // keys must come out of reset as zero
   task automatic test_reset_keys();
      sender_idles = 1'b0;
      send_block('0, '0);
      send_block('1, '1);
      send_block(32'h0123_4567, 32'h89ab_cdef);
      wait_for_drain();
   endtask

   // field and key extremes, a few patterns, each key word alone
   task automatic test_extremes();
      sender_idles = 1'b0;
      load_keys('1, '1, '1, '1);
      send_block('0, '0);
      send_block('1, '0);
      send_block('0, '1);
      send_block('1, '1);
      send_block(32'haaaa_aaaa, 32'h5555_5555);
      send_block(32'h8000_0000, 32'h0000_0001);
      wait_for_drain();
      load_keys(CSR_KEY_0 == CSR_KEY_0 ? 32'h1 : '0, '0, '0, '0);
      send_block(32'hdead_beef, 32'hcafe_f00d);
      send_block('1, '1);
      wait_for_drain();
      load_keys('0, 32'h8000_0000, '0, '0);
      send_block(32'hdead_beef, 32'hcafe_f00d);
      wait_for_drain();
      load_keys('0, '0, 32'hffff_0000, '0);
      send_block(32'hdead_beef, 32'hcafe_f00d);
      wait_for_drain();
      load_keys('0, '0, '0, 32'h0000_ffff);
      send_block(32'hdead_beef, 32'hcafe_f00d);
      send_block(32'h0000_0001, 32'h8000_0000);
      wait_for_drain();
   endtask

   // one long burst with start held high throughout
   task automatic test_back_to_back();
      sender_idles = 1'b0;
      load_keys($urandom, $urandom, $urandom, $urandom);
      repeat (250) send_block(pick_word(), pick_word());
      wait_for_drain();
   endtask

   // several key settings, random gaps on the sender side
   task automatic test_random_traffic();
      sender_idles = 1'b1;
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: begin
               load_keys('0, '0, '0, '0);
            end
            1: begin
               load_keys('1, '1, '1, '1);
            end
            2: begin
               load_keys('1, '0, '1, '0);
            end
            default: begin
               load_keys(pick_word(), pick_word(), pick_word(), pick_word());
            end
         endcase
         repeat (105) send_block(pick_word(), pick_word());
         wait_for_drain();
      end
   endtask

   // compare each result against the oldest owed ciphertext
   always @(posedge clock) begin
      cipher_words_type want;
      if (!reset && rsp_valid) begin
         if (pending_ciphertexts.size() == 0) begin
            note_failure($sformatf("unexpected result left=%h right=%h",
                                   rsp_left_out, rsp_right_out));
         end else begin
            want = pending_ciphertexts.pop_front();
            if (rsp_left_out !== want.left || rsp_right_out !== want.right) begin
               note_failure($sformatf("expected left=%h right=%h, got left=%h right=%h",
                                      want.left, want.right, rsp_left_out, rsp_right_out));
            end
         end
      end
   end

   initial begin
      failure_count = 0;
      sender_idles  = 1'b0;
      for (int i = 0; i < 4; i++) key_shadow[i] = '0;
      reset            <= 1'b1;
      start            <= 1'b0;
      req_left_in      <= '0;
      req_right_in     <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= CSR_KEY_0;
      csr_write_data   <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_keys();
      test_extremes();
      test_back_to_back();
      test_random_traffic();

      // let any stray result surface before the verdict
      start <= 1'b0;
      repeat (PIPE_LATENCY + 16) @(posedge clock);
      while (pending_ciphertexts.size() != 0) begin
         void'(pending_ciphertexts.pop_front());
         note_failure("result never arrived");
      end
      if (failure_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
